// File: rtl/scc_pkg.sv
// shared types and constants for the strongly connected components core
// no dependencies
`timescale 1ns / 1ps

package scc_pkg;

  // storage slots of the graph; vertex fields are 5 bits wide
  localparam int unsigned SLOTS = 32;

  // operation codes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_SOLVE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [4:0] source_vertex;
    logic [4:0] target_vertex;
  } in_item_t;

  typedef struct packed {
    logic [4:0] vertex;
    logic [4:0] component;
    logic       first_in_component;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_ROOT,
    S_RD,
    S_EXP,
    S_POP,
    S_P2,
    S_P2V,
    S_EMIT,
    S_FLUSH
  } state_t;

endpackage

// File: rtl/scc_ram.sv
// generic single write, single read synchronous ram with registered read
// no dependencies
`timescale 1ns / 1ps

module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/strongly_connected_components_core.sv
// kosaraju strongly connected components core, top level
// depends on scc_pkg and scc_ram
`timescale 1ns / 1ps
//
// Input channel (in_valid, in_stall, in_data) takes one op per transaction:
// clear graph, add directed edge, or solve. Result channel (out_valid,
// out_stall, out_data) returns, for a solve of a graph with edges, one
// transaction per vertex in use: vertex, component number, first flag, and
// last on the final one. cfg_valid/cfg_ready writes vertex_count; write it
// only while idle. Clear drops the row valid flags at once; add edge reads,
// then writes, one forward and one reverse row.
// Solve is a depth-first sequencer around the adjacency, stack and finish
// order rams: a vertex found takes a row read and a probe, a return to its
// parent a stack read, a row read and a probe, and the second pass adds an
// emit step per vertex and a finish order read and check per entry.
// One result is held back to set the last flag, so a result leaves the core
// once the next one is found, or at the flush at the end.
// in_stall stays high while an op is in progress.
// A stalled receiver freezes the output register; the sequencer waits at
// its next result until the register frees.
// Synchronous reset empties the graph, sets vertex_count to 32 and drops
// out_valid; no clearing pass is needed.
//

module strongly_connected_components_core #(
  parameter int VERTICES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  scc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output scc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [5:0]         cfg_data
);

  localparam int LIM = (VERTICES < 32) ? VERTICES : 32;

  scc_pkg::state_t state_r, state_nxt;

  logic [5:0]  vc_r, vc_nxt;
  logic        edges_r, edges_nxt;
  logic [31:0] fvld_r, fvld_nxt, rvld_r, rvld_nxt;
  logic        fok_r, fok_nxt, rok_r, rok_nxt;
  logic [4:0]  src_r, src_nxt, dst_r, dst_nxt;
  logic [5:0]  i_r, i_nxt;
  logic [4:0]  top_r, top_nxt;
  logic [5:0]  depth_r, depth_nxt;
  logic [31:0] visited_r, visited_nxt;
  logic [5:0]  fcount_r, fcount_nxt;
  logic [5:0]  comp_r, comp_nxt;
  logic        first_r, first_nxt;
  logic        ph2_r, ph2_nxt;
  scc_pkg::out_item_t pend_r, pend_nxt, out_r, out_nxt;
  logic        pend_vld_r, pend_vld_nxt, out_vld_r, out_vld_nxt;

  // ram ports
  logic        f_we, r_we, s_we, o_we;
  logic [4:0]  f_wa, r_wa, f_ra, r_ra, s_wa, s_ra, o_wa, o_ra;
  logic [31:0] f_wd, r_wd, f_rd, r_rd;
  logic [4:0]  s_wd, s_rd, o_wd, o_rd;

  scc_ram #(.WIDTH(32), .DEPTH(scc_pkg::SLOTS)) u_fwd (
    .clk, .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd), .rd_addr(f_ra), .rd_data(f_rd));
  scc_ram #(.WIDTH(32), .DEPTH(scc_pkg::SLOTS)) u_rev (
    .clk, .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd), .rd_addr(r_ra), .rd_data(r_rd));
  scc_ram #(.WIDTH(5), .DEPTH(scc_pkg::SLOTS)) u_stack (
    .clk, .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd), .rd_addr(s_ra), .rd_data(s_rd));
  scc_ram #(.WIDTH(5), .DEPTH(scc_pkg::SLOTS)) u_finish (
    .clk, .wr_en(o_we), .wr_addr(o_wa), .wr_data(o_wd), .rd_addr(o_ra), .rd_data(o_rd));

  // index of lowest set bit
  function automatic logic [4:0] low_index(input logic [31:0] m);
    logic [31:0] iso;
    logic [4:0]  idx;
    iso = m & (~m + 32'd1);
    idx = '0;
    for (int b = 0; b < 5; b++) begin
      for (int k = 0; k < 32; k++) begin
        if (((k >> b) & 1) == 1) idx[b] = idx[b] | iso[k];
      end
    end
    return idx;
  endfunction

  // vertices in use and active mask
  logic [5:0]  n_use;
  logic [31:0] active;
  always_comb begin
    n_use = (vc_r > 6'(LIM)) ? 6'(LIM) : vc_r;
    for (int k = 0; k < 32; k++) active[k] = (6'(k) < n_use);
  end

  logic        in_acc, slot_free, src_ok, dst_ok;
  logic [31:0] row, cand;
  logic [4:0]  u_idx;
  logic        can_push;
  always_comb begin
    in_acc    = in_valid && !in_stall;
    slot_free = !out_vld_r || !out_stall;
    src_ok    = (32'(src_r) < VERTICES);
    dst_ok    = (32'(dst_r) < VERTICES);
    row       = ph2_r ? (rok_r ? r_rd : '0) : (fok_r ? f_rd : '0);
    cand      = row & active & ~visited_r;
    u_idx     = low_index(cand);
    can_push  = (cand != '0) && (depth_r < 6'd32);
  end

  assign in_stall  = (state_r != scc_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scc_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.op == scc_pkg::OP_ADD) state_nxt = scc_pkg::S_ADD;
          else if (in_data.op == scc_pkg::OP_SOLVE && edges_r && n_use != '0)
            state_nxt = scc_pkg::S_ROOT;
        end
      end
      scc_pkg::S_ADD: state_nxt = scc_pkg::S_IDLE;
      scc_pkg::S_ROOT: begin
        if (i_r == n_use) state_nxt = scc_pkg::S_P2;
        else if (!visited_r[i_r[4:0]]) state_nxt = scc_pkg::S_RD;
      end
      scc_pkg::S_RD: state_nxt = scc_pkg::S_EXP;
      scc_pkg::S_EXP: begin
        if (can_push) state_nxt = ph2_r ? scc_pkg::S_EMIT : scc_pkg::S_RD;
        else if (depth_r == 6'd1) state_nxt = ph2_r ? scc_pkg::S_P2 : scc_pkg::S_ROOT;
        else state_nxt = scc_pkg::S_POP;
      end
      scc_pkg::S_POP: state_nxt = scc_pkg::S_RD;
      scc_pkg::S_P2: state_nxt = (i_r == '0) ? scc_pkg::S_FLUSH : scc_pkg::S_P2V;
      scc_pkg::S_P2V: state_nxt = visited_r[o_rd] ? scc_pkg::S_P2 : scc_pkg::S_EMIT;
      scc_pkg::S_EMIT: if (slot_free) state_nxt = scc_pkg::S_RD;
      scc_pkg::S_FLUSH: if (slot_free) state_nxt = scc_pkg::S_IDLE;
      default: state_nxt = scc_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    vc_nxt = vc_r;         edges_nxt = edges_r;
    fvld_nxt = fvld_r;     rvld_nxt = rvld_r;
    src_nxt = src_r;       dst_nxt = dst_r;
    i_nxt = i_r;           top_nxt = top_r;
    depth_nxt = depth_r;   visited_nxt = visited_r;
    fcount_nxt = fcount_r; comp_nxt = comp_r;
    first_nxt = first_r;   ph2_nxt = ph2_r;
    pend_nxt = pend_r;     pend_vld_nxt = pend_vld_r;
    out_nxt = out_r;       out_vld_nxt = out_vld_r;
    f_we = 1'b0; r_we = 1'b0; s_we = 1'b0; o_we = 1'b0;
    f_wa = src_r; r_wa = dst_r;
    f_wd = (fok_r ? f_rd : '0) | (32'd1 << dst_r);
    r_wd = (rok_r ? r_rd : '0) | (32'd1 << src_r);
    f_ra = top_r; r_ra = top_r;
    s_wa = depth_r[4:0]; s_wd = u_idx; s_ra = 5'(depth_r - 6'd2);
    o_wa = fcount_r[4:0]; o_wd = top_r; o_ra = 5'(i_r - 6'd1);

    // output register drains on a transaction
    if (out_vld_r && !out_stall) out_vld_nxt = 1'b0;
    // configuration write
    if (cfg_valid) vc_nxt = cfg_data;

    unique case (state_r)
      scc_pkg::S_IDLE: begin
        f_ra = in_data.source_vertex;
        r_ra = in_data.target_vertex;
        if (in_acc) begin
          src_nxt = in_data.source_vertex;
          dst_nxt = in_data.target_vertex;
          if (in_data.op == scc_pkg::OP_CLEAR) begin
            fvld_nxt = '0; rvld_nxt = '0; edges_nxt = 1'b0;
          end else if (in_data.op == scc_pkg::OP_SOLVE) begin
            visited_nxt = '0; fcount_nxt = '0; i_nxt = '0; ph2_nxt = 1'b0;
          end
        end
      end
      scc_pkg::S_ADD: begin
        if (src_ok && dst_ok) begin
          f_we = 1'b1; r_we = 1'b1;
          fvld_nxt[src_r] = 1'b1; rvld_nxt[dst_r] = 1'b1;
          edges_nxt = 1'b1;
        end
      end
      scc_pkg::S_ROOT: begin
        if (i_r == n_use) begin
          visited_nxt = '0; comp_nxt = '0; i_nxt = fcount_r; ph2_nxt = 1'b1;
        end else if (visited_r[i_r[4:0]]) begin
          i_nxt = i_r + 6'd1;
        end else begin
          visited_nxt[i_r[4:0]] = 1'b1;
          s_we = 1'b1; s_wa = '0; s_wd = i_r[4:0];
          depth_nxt = 6'd1; top_nxt = i_r[4:0];
        end
      end
      scc_pkg::S_EXP: begin
        if (can_push) begin
          visited_nxt[u_idx] = 1'b1;
          s_we = 1'b1;
          depth_nxt = depth_r + 6'd1;
          top_nxt = u_idx;
          first_nxt = 1'b0;
        end else begin
          if (!ph2_r && fcount_r < 6'd32) begin
            o_we = 1'b1;
            fcount_nxt = fcount_r + 6'd1;
          end
          depth_nxt = depth_r - 6'd1;
          if (depth_r == 6'd1) begin
            if (ph2_r) begin
              comp_nxt = comp_r + 6'd1;
              i_nxt = i_r - 6'd1;
            end else begin
              i_nxt = i_r + 6'd1;
            end
          end
        end
      end
      scc_pkg::S_POP: top_nxt = s_rd;
      scc_pkg::S_P2V: begin
        if (visited_r[o_rd]) begin
          i_nxt = i_r - 6'd1;
        end else begin
          visited_nxt[o_rd] = 1'b1;
          s_we = 1'b1; s_wa = '0; s_wd = o_rd;
          depth_nxt = 6'd1; top_nxt = o_rd; first_nxt = 1'b1;
        end
      end
      scc_pkg::S_EMIT: begin
        if (slot_free) begin
          if (pend_vld_r) begin
            out_nxt = pend_r; out_vld_nxt = 1'b1;
          end
          pend_nxt = '{vertex: top_r, component: comp_r[4:0],
                       first_in_component: first_r, last: 1'b0};
          pend_vld_nxt = 1'b1;
        end
      end
      scc_pkg::S_FLUSH: begin
        if (slot_free) begin
          out_nxt = pend_r; out_nxt.last = 1'b1;
          out_vld_nxt = pend_vld_r; pend_vld_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // row valid flags are registered with the read address, so they line up with the read data
  always_comb begin
    fok_nxt = fvld_r[f_ra];
    rok_nxt = rvld_r[r_ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scc_pkg::S_IDLE;
      vc_r <= 6'd32;
      edges_r <= 1'b0;
      fvld_r <= '0;
      rvld_r <= '0;
      pend_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      vc_r <= vc_nxt;
      edges_r <= edges_nxt;
      fvld_r <= fvld_nxt;
      rvld_r <= rvld_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    fok_r <= fok_nxt;   rok_r <= rok_nxt;
    src_r <= src_nxt;   dst_r <= dst_nxt;
    i_r <= i_nxt;       top_r <= top_nxt;
    depth_r <= depth_nxt;
    visited_r <= visited_nxt;
    fcount_r <= fcount_nxt;
    comp_r <= comp_nxt; first_r <= first_nxt;
    ph2_r <= ph2_nxt;
    pend_r <= pend_nxt; out_r <= out_nxt;
  end

endmodule

// File: rtl/scc_checker.sv
// port level checks for the strongly connected components core
// depends on scc_pkg; bound to strongly_connected_components_core
`timescale 1ns / 1ps

module scc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input scc_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input scc_pkg::out_item_t out_data,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [5:0]         cfg_data
);

  // reset empties the output register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // add edge keeps the block busy for its write cycle
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.op == scc_pkg::OP_ADD |=> in_stall)
    else $error("add edge not busy");

  // nothing follows the final result of a solve at once
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last |=> !out_valid)
    else $error("result right after last");

endmodule

bind strongly_connected_components_core scc_checker u_scc_checker (.*);
